[hdl/sem_pkg.sv]
`timescale 1ns / 1ps

package sem_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int LUMA_W     = 24;
  localparam int GRAD_W     = 10;
  localparam int SQ_W       = 20;
  localparam int SQ_IN_W    = 21;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // luma weights in unsigned Q0.16, they sum to 65536
  localparam logic [15:0] WEIGHT_R = 16'd13933;
  localparam logic [15:0] WEIGHT_G = 16'd46871;
  localparam logic [15:0] WEIGHT_B = 16'd4732;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GRAD,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_OUT
  } state_e;

  // one line store entry: the row two above and the row just above
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
  } line_pair_t;

endpackage

[hdl/sobel_edge_magnitude_top.sv]
`timescale 1ns / 1ps
// throughput: one pixel in flight; input stalls until a border pixel's line store write is done,
//   or an interior result is loaded after the 8-step square root unit and any output stall
// reset: counters, handshakes and the sequencer clear; width 640, height 480;
//   line store contents are left as they are, they are rewritten before use in every frame
module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sem_pkg::PIX_W-1:0]      red_i,
  input  logic [sem_pkg::PIX_W-1:0]      green_i,
  input  logic [sem_pkg::PIX_W-1:0]      blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sem_pkg::PIX_W-1:0]      magnitude_o,
  output logic [sem_pkg::ROW_W-1:0]      out_row_o,
  output logic [sem_pkg::OUT_COL_W-1:0]  out_col_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  state_e state_q, state_d;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [CW-1:0]       col_q;
  logic [ROW_W-1:0]    row_q;

  logic in_fire, cfg_fire, cfg_hit, slot_free;
  logic mem_we, sq_start, out_load;

  logic [PIX_W-1:0]  red_q, green_q, blue_q;
  logic [LUMA_W-1:0] pr_q, pg_q, pb_q, luma_sum;
  logic [PIX_W-1:0]  grey;
  line_pair_t        rd_pair, wr_pair;

  logic [PIX_W-1:0] win_q [3][3];

  logic [31:0] eff_w, col_wide, width_wide;
  logic [HEIGHT_W-1:0] eff_h;
  logic col_last, row_last, interior;

  logic [ROW_W-1:0]     pos_row_q;
  logic [OUT_COL_W-1:0] pos_col_q;
  logic                 pos_last_q;

  logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;
  logic [GRAD_W-1:0] ax_q, ay_q;
  logic [SQ_W-1:0]   sqx_q, sqy;
  logic [SQ_IN_W-1:0] sq_in;
  logic              sq_done;
  logic [PIX_W-1:0]  sq_root;

  logic                 out_valid_q;
  logic [PIX_W-1:0]     mag_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [OUT_COL_W-1:0] out_col_q;
  logic                 last_q;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // effective frame size
  always_comb begin
    width_wide = 32'(width_q);
    eff_w      = width_wide;
    if (width_wide < 32'd3) begin
      eff_w = 32'd3;
    end else if (width_wide > 32'(MAX_WIDTH)) begin
      eff_w = 32'(MAX_WIDTH);
    end
    eff_h = height_q;
    if (height_q < 13'd3) begin
      eff_h = 13'd3;
    end else if (height_q > 13'(MAX_HEIGHT)) begin
      eff_h = 13'(MAX_HEIGHT);
    end
  end

  assign col_wide = 32'(col_q);
  assign col_last = (col_wide == eff_w - 32'd1);
  assign row_last = ({1'b0, row_q} == eff_h - 13'd1);
  assign interior = (row_q >= 12'd2) && (col_wide >= 32'd2);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  state_d = interior ? ST_GRAD : ST_IDLE;
      ST_GRAD: state_d = ST_SQX;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (sq_done) begin
          state_d = slot_free ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    mem_we     = 1'b0;
    sq_start   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SUM:  mem_we = 1'b1;
      ST_SQY:  sq_start = 1'b1;
      ST_ROOT: out_load = sq_done && slot_free;
      ST_OUT:  out_load = slot_free;
      default: ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_index_i)
      REG_IMAGE_WIDTH:  cfg_hit = 1'b1;
      REG_IMAGE_HEIGHT: cfg_hit = 1'b1;
      default:          cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire && cfg_hit) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) begin
          width_q <= cfg_data_i[WIDTH_W-1:0];
        end else begin
          height_q <= cfg_data_i[HEIGHT_W-1:0];
        end
        col_q <= '0;
        row_q <= '0;
      end else if (mem_we) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + 12'd1;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // line store: one entry per column holds the two rows above
  assign luma_sum    = pr_q + pg_q + pb_q;
  assign grey        = luma_sum[LUMA_W-1:LUMA_W-PIX_W];
  assign wr_pair.top = rd_pair.mid;
  assign wr_pair.mid = grey;

  sem_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (col_q),
    .rd_data_o (rd_pair),
    .wr_en_i   (mem_we),
    .wr_addr_i (col_q),
    .wr_data_i (wr_pair)
  );

  // gradient sums; the middle row and column are weighted by two
  assign pos_x = GRAD_W'(win_q[0][2]) + {1'b0, win_q[1][2], 1'b0} + GRAD_W'(win_q[2][2]);
  assign neg_x = GRAD_W'(win_q[0][0]) + {1'b0, win_q[1][0], 1'b0} + GRAD_W'(win_q[2][0]);
  assign pos_y = GRAD_W'(win_q[0][0]) + {1'b0, win_q[0][1], 1'b0} + GRAD_W'(win_q[0][2]);
  assign neg_y = GRAD_W'(win_q[2][0]) + {1'b0, win_q[2][1], 1'b0} + GRAD_W'(win_q[2][2]);

  assign sqy   = SQ_W'(ay_q) * SQ_W'(ay_q);
  assign sq_in = SQ_IN_W'(sqx_q) + SQ_IN_W'(sqy);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (state_q == ST_MUL) begin
      pr_q <= LUMA_W'(WEIGHT_R) * LUMA_W'(red_q);
      pg_q <= LUMA_W'(WEIGHT_G) * LUMA_W'(green_q);
      pb_q <= LUMA_W'(WEIGHT_B) * LUMA_W'(blue_q);
    end
    if (mem_we) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_pair.top;
      win_q[1][2] <= rd_pair.mid;
      win_q[2][2] <= grey;
      pos_row_q   <= row_q - 12'd1;
      pos_col_q   <= col_wide[OUT_COL_W-1:0] - 10'd1;
      pos_last_q  <= row_last && col_last;
    end
    if (state_q == ST_GRAD) begin
      ax_q <= (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
      ay_q <= (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;
    end
    if (state_q == ST_SQX) begin
      sqx_q <= SQ_W'(ax_q) * SQ_W'(ax_q);
    end
    if (out_load) begin
      mag_q     <= sq_root;
      out_row_q <= pos_row_q;
      out_col_q <= pos_col_q;
      last_q    <= pos_last_q;
    end
  end

  sem_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_in),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign last_o      = last_q;

endmodule

[hdl/sem_line_mem.sv]
`timescale 1ns / 1ps

module sem_line_mem #(
  parameter int DEPTH = sem_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output sem_pkg::line_pair_t rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  sem_pkg::line_pair_t wr_data_i
);
  import sem_pkg::*;

  line_pair_t mem_q [DEPTH];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/sem_isqrt.sv]
`timescale 1ns / 1ps

module sem_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sem_pkg::SQ_IN_W-1:0] value_i,
  output logic                        done_o,
  output logic [sem_pkg::PIX_W-1:0]   root_o
);
  import sem_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] x_q, x_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  root_q, root_d;
  logic        sat_q, sat_d;

  logic [10:0] rem_shift;
  logic [10:0] trial;

  // restoring square root, two radicand bits per step
  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    rem_d     = rem_q;
    root_d    = root_q;
    sat_d     = sat_q;
    done_d    = busy_q && (cnt_q == 3'd7);
    rem_shift = {rem_q[8:0], x_q[15:14]};
    trial     = {1'b0, root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = value_i[15:0];
      sat_d  = |value_i[SQ_IN_W-1:16];
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      x_d   = {x_q[13:0], 2'b00};
      cnt_d = cnt_q + 3'd1;
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[6:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[6:0], 1'b0};
      end
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sat_q  <= sat_d;
  end

  assign done_o = done_q;
  assign root_o = sat_q ? 8'hFF : root_q;

endmodule

[hdl/sem_checker.sv]
`timescale 1ns / 1ps

module sem_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [sem_pkg::PIX_W-1:0]      magnitude_o,
  input logic [sem_pkg::ROW_W-1:0]      out_row_o,
  input logic [sem_pkg::OUT_COL_W-1:0]  out_col_o,
  input logic                           last_o
);

  // a pending result holds still until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(magnitude_o)
      && $stable(out_row_o) && $stable(out_col_o) && $stable(last_o))
    else $error("result changed while stalled");

  // one pixel in flight: input closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second pixel taken while one is in flight");

  // a new result is only loaded while the sequencer is busy
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a pixel in flight");

  // interior centres never sit on the top row
  a_row_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_row_o != '0)
    else $error("result on a border row");

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (.*);

[tb/sobel_edge_magnitude_top_tb.sv]
`timescale 1ns / 1ps

module sobel_edge_magnitude_top_tb;
  import sem_pkg::*;

  localparam int unsigned LINE_DEPTH     = MAX_WIDTH_DEF;
  localparam int unsigned HEIGHT_CAP     = MAX_HEIGHT;
  localparam int unsigned LUMA_R         = 13933;
  localparam int unsigned LUMA_G         = 46871;
  localparam int unsigned LUMA_B         = 4732;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // pixel content styles
  localparam int unsigned PIX_RANDOM  = 0;
  localparam int unsigned PIX_EXTREME = 1;
  localparam int unsigned PIX_GREY    = 2;

  typedef struct packed {
    logic [PIX_W-1:0]     magnitude;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } edge_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  pix_valid;
  logic                  pix_stall;
  logic [PIX_W-1:0]      red;
  logic [PIX_W-1:0]      green;
  logic [PIX_W-1:0]      blue;
  logic                  res_valid;
  logic                  res_stall;
  logic [PIX_W-1:0]      magnitude;
  logic [ROW_W-1:0]      res_row;
  logic [OUT_COL_W-1:0]  res_col;
  logic                  res_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the block state
  logic [PIX_W-1:0] prev_row [LINE_DEPTH];
  logic [PIX_W-1:0] prev_prev_row [LINE_DEPTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      cur_col;
  int unsigned      cur_row;
  int unsigned      width_reg;
  int unsigned      height_reg;

  edge_result_t pending_edges[$];
  edge_result_t head;
  int unsigned  errors = 0;
  int unsigned  pixels_sent = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  stall_hold = 0;
  int unsigned  quiet_cycles = 0;

  sobel_edge_magnitude_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_stall_o  (pix_stall),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .magnitude_o (magnitude),
    .out_row_o   (res_row),
    .out_col_o   (res_col),
    .last_o      (res_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned clamp_size(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic reset_shadow();
    for (int i = 0; i < LINE_DEPTH; i++) begin
      prev_row[i] = '0;
      prev_prev_row[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    end
    cur_col = 0;
    cur_row = 0;
    width_reg = 32'(WIDTH_RESET);
    height_reg = 32'(HEIGHT_RESET);
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = 32'(value[WIDTH_W-1:0]);
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = 32'(value[HEIGHT_W-1:0]);
    end else begin
      return;
    end
    cur_col = 0;
    cur_row = 0;
  endtask

  // advance the shadow by one pixel and queue the gradient it produces
  task automatic predict_gradient(input logic [PIX_W-1:0] r, g, b);
    int unsigned  ew;
    int unsigned  eh;
    int unsigned  lum;
    int unsigned  sq;
    int unsigned  mag;
    int           gx;
    int           gy;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    edge_result_t res;
    ew = clamp_size(width_reg, 3, LINE_DEPTH);
    eh = clamp_size(height_reg, 3, HEIGHT_CAP);
    lum = (LUMA_R * r + LUMA_G * g + LUMA_B * b) >> 16;
    top = prev_prev_row[cur_col];
    mid = prev_row[cur_col];
    prev_prev_row[cur_col] = mid;
    prev_row[cur_col] = lum[PIX_W-1:0];
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = lum[PIX_W-1:0];
    if (cur_row >= 2 && cur_col >= 2) begin
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]))
         - (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]));
      sq = gx * gx + gy * gy;
      mag = 0;
      while (mag < 255 && (mag + 1) * (mag + 1) <= sq) mag++;
      res.magnitude = mag[PIX_W-1:0];
      res.row = ROW_W'(cur_row - 1);
      res.col = OUT_COL_W'(cur_col - 1);
      res.last = (cur_row == eh - 1) && (cur_col == ew - 1);
      pending_edges.push_back(res);
    end
    cur_col++;
    if (cur_col >= ew) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= eh) cur_row = 0;
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
    @(negedge clk);
    // each cycle the sender stays idle with the set probability
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (pix_stall);
    predict_gradient(r, g, b);
    pixels_sent++;
  endtask

  function automatic logic [3*PIX_W-1:0] make_pixel(input int unsigned style);
    logic [PIX_W-1:0] lvl;
    case (style)
      PIX_EXTREME: begin
        return {{PIX_W{$urandom_range(0, 1) == 1}}, {PIX_W{$urandom_range(0, 1) == 1}},
                {PIX_W{$urandom_range(0, 1) == 1}}};
      end
      PIX_GREY: begin
        lvl = PIX_W'($urandom_range(0, 255));
        return {lvl, lvl, lvl};
      end
      default: begin
        return (3*PIX_W)'($urandom_range(0, 24'hFFFFFF));
      end
    endcase
  endfunction

  task automatic send_random_pixels(input int unsigned count, input int unsigned style);
    logic [3*PIX_W-1:0] px;
    for (int unsigned i = 0; i < count; i++) begin
      px = make_pixel(style);
      send_pixel(px[23:16], px[15:8], px[7:0]);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop sending, wait for every queued result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    idle_pct = sender_pct;
    stall_pct = receiver_pct;
  endtask

  task automatic test_directed_extremes();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    // white left column on black: strongest horizontal gradient, saturates
    for (int i = 0; i < 9; i++) begin
      if (i % 3 == 0) send_pixel(8'd255, 8'd255, 8'd255);
      else send_pixel(8'd0, 8'd0, 8'd0);
    end
    // second frame after the counters wrap, one primary at a time
    for (int i = 0; i < 9; i++) begin
      case (i % 4)
        0: send_pixel(8'd255, 8'd0, 8'd0);
        1: send_pixel(8'd0, 8'd255, 8'd0);
        2: send_pixel(8'd0, 8'd0, 8'd255);
        default: send_pixel(8'd0, 8'd0, 8'd0);
      endcase
    end
    settle();
  endtask

  task automatic test_clamped_small_size();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    send_random_pixels(9, PIX_EXTREME);
    settle();
  endtask

  task automatic test_random_frames(input int unsigned count);
    int unsigned start;
    int unsigned ew;
    int unsigned eh;
    int unsigned frame_px;
    int unsigned cut;
    int unsigned style;
    int unsigned choice;
    start = pixels_sent;
    while (pixels_sent - start < count) begin
      settle();
      choice = $urandom_range(0, 9);
      if (choice != 9 || $urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 99) < 85) begin
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 16)));
        end else begin
          write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(17, 64)));
        end
      end
      if (choice != 8) write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 7)));
      ew = clamp_size(width_reg, 3, LINE_DEPTH);
      eh = clamp_size(height_reg, 3, HEIGHT_CAP);
      frame_px = ew * eh;
      style = $urandom_range(0, 3);
      if (style > PIX_GREY) style = PIX_RANDOM;
      if (choice <= 5) begin
        send_random_pixels(frame_px * $urandom_range(1, 2), style);
      end else if (choice == 6) begin
        // sender drains mid-frame, then an unused index must not move the counters
        cut = $urandom_range(1, frame_px - 1);
        send_random_pixels(cut, style);
        settle();
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom_range(0, 8191)));
        send_random_pixels(frame_px - cut, style);
      end else begin
        // abandoned frame, the next write starts over
        send_random_pixels($urandom_range(1, frame_px - 1), style);
      end
    end
    settle();
  endtask

  task automatic test_backpressure_fill();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd9);
    write_reg(REG_IMAGE_HEIGHT, 13'd7);
    for (int i = 0; i < 63; i++) begin
      if (i == 30) stall_hold = HOLD_CYCLES;
      send_random_pixels(1, PIX_RANDOM);
      if (i == 45) settle();
    end
    settle();
  endtask

  task automatic test_tallest_frame();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    send_random_pixels(15, PIX_RANDOM);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 13'd4096);
    send_random_pixels(15, PIX_EXTREME);
    settle();
  endtask

  task automatic test_widest_frame();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd1024);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    // oversized width clamps to the line store depth; the frame stays on its
    // first row, so no result may come
    write_reg(REG_IMAGE_WIDTH, 13'd2047);
    send_random_pixels(150, PIX_RANDOM);
    settle();
  endtask

  task automatic check_field(input string name, input int unsigned expv, input int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (res_valid && !res_stall) begin
      if (pending_edges.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual magnitude %0d row %0d col %0d last %0d",
                 $time, magnitude, res_row, res_col, res_last);
        errors++;
      end else begin
        head = pending_edges.pop_front();
        check_field("magnitude", 32'(head.magnitude), 32'(magnitude));
        check_field("out_row", 32'(head.row), 32'(res_row));
        check_field("out_col", 32'(head.col), 32'(res_col));
        check_field("last", 32'(head.last), 32'(res_last));
      end
    end
  end

  always @(negedge clk) begin
    if (stall_hold > 0) begin
      res_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_edges.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    pix_valid = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    res_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    reset_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_extremes();
    test_clamped_small_size();
    set_idling(0, 0);
    test_random_frames(260);
    set_idling(53, 0);
    test_random_frames(260);
    set_idling(0, 53);
    test_random_frames(260);
    set_idling(33, 33);
    test_random_frames(260);
    set_idling(0, 0);
    test_backpressure_fill();
    test_tallest_frame();
    test_widest_frame();
    settle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
